[rtl/rfpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpr_pkg
// Shared types, codes and defaults of the refcounted frame pool ring.
// ----------------------------------------------------------------------------
package rfpr_pkg;

    localparam int DEF_MAX_ACTIVE = 16;
    localparam int DEF_MAX_BLOCKS = 32;
    localparam int DEF_REF_WIDTH  = 8;

    // width of the small arithmetic on sizes and pointers
    localparam int XW = 8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_BLOCKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD     = 2'd2;

    localparam logic [4:0]  RST_ACTIVE_CAPACITY = 5'd16;
    localparam logic [4:0]  RST_RESERVE_BLOCKS  = 5'd16;
    localparam logic [23:0] RST_MAX_PAYLOAD     = 24'd1048576;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_FREEZE  = 2'd1,
        REQ_ADD     = 2'd2,
        REQ_RELEASE = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_STORED     = 4'd0,
        ST_INCOMPLETE = 4'd1,
        ST_TOO_LARGE  = 4'd2,
        ST_EXHAUSTED  = 4'd3,
        ST_REF_ADDED  = 4'd4,
        ST_REF_REFUSE = 4'd5,
        ST_REL_ERROR  = 4'd6,
        ST_SNAP_ENTRY = 4'd7,
        ST_SNAP_EMPTY = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        RS_CAND = 2'd0,
        RS_OLD  = 2'd1,
        RS_SLOT = 2'd2,
        RS_TGT  = 2'd3
    } t_rd_sel;

    typedef enum logic [1:0] {
        WK_NONE = 2'd0,
        WK_SET1 = 2'd1,
        WK_INC  = 2'd2,
        WK_DEC  = 2'd3
    } t_wr_kind;

    typedef struct packed {
        logic     load;
        logic     rd;
        t_rd_sel  rd_sel;
        t_wr_kind wr_kind;
        logic     scan_clr;
        logic     cand_step;
        logic     claim;
        logic     reuse;
        logic     walk_init;
        logic     walk_step;
        logic     mark;
        logic     slot_walk;
        logic     emit;
        t_status  code;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic complete;
        logic too_large;
        logic tgt_out;
        logic fill_zero;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_max;
        logic scan_last;
        logic slot_valid;
        logic walk_valid;
        logic walk_last;
        logic walk_at_mark;
        logic out_free;
    } t_sts;

endpackage

[rtl/refcounted_frame_pool_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_frame_pool_ring
// Reference counted frame block pool with a ring of active slots.
// ----------------------------------------------------------------------------
//  channel   direction  signals                      contents
//  s         in         i_s_tvalid/o_s_tready        request: push, freeze, add, release
//  m         out        o_m_tvalid/i_m_tready        status, block, position, fill
//  cfg       in         i_cfg_valid/o_cfg_ready      register index and value
//
//  one request at a time, taken only in the idle state; counts live in a ram
//  with one registered read port, so each count visit is a read state followed
//  by a check/write state. a push scans blocks for a free count and may then
//  release a displaced block; a freeze pins each slot and then emits one entry
//  per slot; add and release check and write one count.
//  reset is synchronous and clears all counts and slots.
//  a full result register holds the sequencer in its result state, so it also stalls request intake.
// ----------------------------------------------------------------------------
module refcounted_frame_pool_ring #(
    parameter int MAX_ACTIVE = rfpr_pkg::DEF_MAX_ACTIVE,
    parameter int MAX_BLOCKS = rfpr_pkg::DEF_MAX_BLOCKS,
    parameter int REF_WIDTH  = rfpr_pkg::DEF_REF_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [31:0]                     i_s_tdata,  // frame_complete, payload_length, target_block
    input  logic [1:0]                      i_s_tuser,  // req_type
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [15:0]                     o_m_tdata,  // result_block, chron_index, ring_fill
    output logic [3:0]                      o_m_tuser,  // status
    output logic                            o_m_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rfpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rfpr_pkg::t_cmd cmd;
    rfpr_pkg::t_sts sts;
    logic [4:0] out_blk;
    logic [3:0] out_chron;
    logic [4:0] out_fill;

    assign o_cfg_ready = 1'b1;

    rfpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rfpr_dp #(
        .MAX_ACTIVE (MAX_ACTIVE),
        .MAX_BLOCKS (MAX_BLOCKS),
        .REF_WIDTH  (REF_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req        (i_s_tuser),
        .i_complete   (i_s_tdata[0]),
        .i_len        (i_s_tdata[24:1]),
        .i_tgt        (i_s_tdata[29:25]),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_status (o_m_tuser),
        .o_out_blk    (out_blk),
        .o_out_chron  (out_chron),
        .o_out_last   (o_m_tlast),
        .o_out_fill   (out_fill)
    );

    assign o_m_tdata = {2'b00, out_fill, out_chron, out_blk};

endmodule

[rtl/rfpr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rfpr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpr_dp
// Datapath: config registers, ring slot table, count memory, result register.
// ----------------------------------------------------------------------------
module rfpr_dp #(
    parameter int MAX_ACTIVE = rfpr_pkg::DEF_MAX_ACTIVE,
    parameter int MAX_BLOCKS = rfpr_pkg::DEF_MAX_BLOCKS,
    parameter int REF_WIDTH  = rfpr_pkg::DEF_REF_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rfpr_pkg::t_cmd                     i_cmd,
    output rfpr_pkg::t_sts                     o_sts,
    input  logic                               i_cfg_valid,
    input  logic [rfpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rfpr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [1:0]                         i_req,
    input  logic                               i_complete,
    input  logic [23:0]                        i_len,
    input  logic [4:0]                         i_tgt,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [3:0]                         o_out_status,
    output logic [4:0]                         o_out_blk,
    output logic [3:0]                         o_out_chron,
    output logic                               o_out_last,
    output logic [4:0]                         o_out_fill
);

    localparam int XW = rfpr_pkg::XW;
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int SW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int CW = $clog2(MAX_ACTIVE + 1);
    localparam int TW = $clog2(MAX_BLOCKS + 1);

    // configuration
    logic [4:0]  r_cfg_cap;
    logic [4:0]  r_cfg_res;
    logic [23:0] r_cfg_max;

    // latched request
    rfpr_pkg::t_req r_req;
    logic           r_complete;
    logic [23:0]    r_len;
    logic [4:0]     r_tgt;

    // pool state
    logic [BW-1:0] r_slot_blk [MAX_ACTIVE];
    logic          r_slot_vld [MAX_ACTIVE];
    logic          r_cnt_vld  [MAX_BLOCKS];
    logic [SW-1:0] r_next;
    logic [CW-1:0] r_fill;
    logic [BW-1:0] r_cand;

    // work registers
    logic [TW-1:0] r_scan_cnt;
    logic [BW-1:0] r_old_blk;
    logic [BW-1:0] r_res_blk;
    logic [BW-1:0] r_rd_addr;
    logic [SW-1:0] r_walk_ptr;
    logic [CW-1:0] r_walk_cnt;
    logic [CW-1:0] r_mark;

    // result register
    logic       r_out_valid;
    logic [3:0] r_out_status;
    logic [4:0] r_out_blk;
    logic [3:0] r_out_chron;
    logic       r_out_last;
    logic [4:0] r_out_fill;

    logic [XW-1:0] cap_x;
    logic [XW-1:0] sum_x;
    logic [XW-1:0] total_x;
    logic [SW-1:0] slot_idx;
    logic [BW-1:0] slot_rd_blk;
    logic          slot_rd_vld;
    logic [BW-1:0] ram_raddr;
    logic [REF_WIDTH-1:0] ram_q;
    logic [REF_WIDTH-1:0] cnt_q;
    logic [REF_WIDTH-1:0] wdata;
    logic          ram_we;
    logic [SW-1:0] next_inc;
    logic [SW-1:0] walk_inc;
    logic [BW-1:0] cand_inc;
    logic [rfpr_pkg::XW-1:0] blk_out_x;

    // effective sizes
    always_comb begin
        if (r_cfg_cap == '0) begin
            cap_x = XW'(1);
        end else if (XW'(r_cfg_cap) > XW'(MAX_ACTIVE)) begin
            cap_x = XW'(MAX_ACTIVE);
        end else begin
            cap_x = XW'(r_cfg_cap);
        end
        sum_x = cap_x + XW'(r_cfg_res);
        total_x = (sum_x > XW'(MAX_BLOCKS)) ? XW'(MAX_BLOCKS) : sum_x;
    end

    assign slot_idx    = i_cmd.slot_walk ? r_walk_ptr : r_next;
    assign slot_rd_blk = r_slot_blk[slot_idx];
    assign slot_rd_vld = r_slot_vld[slot_idx];

    assign next_inc = (XW'(r_next) + XW'(1) == cap_x) ? '0 : r_next + SW'(1);
    assign walk_inc = (XW'(r_walk_ptr) + XW'(1) == cap_x) ? '0 : r_walk_ptr + SW'(1);
    assign cand_inc = (XW'(r_cand) + XW'(1) == total_x) ? '0 : r_cand + BW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            rfpr_pkg::RS_CAND: ram_raddr = r_cand;
            rfpr_pkg::RS_OLD:  ram_raddr = r_old_blk;
            rfpr_pkg::RS_SLOT: ram_raddr = slot_rd_blk;
            rfpr_pkg::RS_TGT:  ram_raddr = BW'(XW'(r_tgt));
            default:           ram_raddr = r_cand;
        endcase
    end

    // a count never written reads as zero
    assign cnt_q = r_cnt_vld[r_rd_addr] ? ram_q : '0;

    always_comb begin
        ram_we = 1'b1;
        case (i_cmd.wr_kind)
            rfpr_pkg::WK_SET1: wdata = REF_WIDTH'(1);
            rfpr_pkg::WK_INC:  wdata = cnt_q + REF_WIDTH'(1);
            rfpr_pkg::WK_DEC:  wdata = (cnt_q == '0) ? '0 : cnt_q - REF_WIDTH'(1);
            default: begin
                wdata  = cnt_q;
                ram_we = 1'b0;
            end
        endcase
    end

    rfpr_ram #(
        .WIDTH (REF_WIDTH),
        .DEPTH (MAX_BLOCKS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rd_addr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cap <= rfpr_pkg::RST_ACTIVE_CAPACITY;
            r_cfg_res <= rfpr_pkg::RST_RESERVE_BLOCKS;
            r_cfg_max <= rfpr_pkg::RST_MAX_PAYLOAD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rfpr_pkg::CFG_ACTIVE_CAPACITY: r_cfg_cap <= i_cfg_data[4:0];
                rfpr_pkg::CFG_RESERVE_BLOCKS:  r_cfg_res <= i_cfg_data[4:0];
                rfpr_pkg::CFG_MAX_PAYLOAD:     r_cfg_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= rfpr_pkg::t_req'(i_req);
            r_complete <= i_complete;
            r_len      <= i_len;
            r_tgt      <= i_tgt;
        end
        if (i_cmd.rd) begin
            r_rd_addr <= ram_raddr;
        end
        if (i_cmd.claim) begin
            r_slot_blk[r_next] <= r_cand;
            r_old_blk          <= slot_rd_blk;
            r_res_blk          <= r_cand;
        end
        if (i_cmd.reuse) begin
            r_res_blk <= slot_rd_blk;
        end
        if (i_cmd.scan_clr) begin
            r_scan_cnt <= '0;
        end else if (i_cmd.cand_step) begin
            r_scan_cnt <= r_scan_cnt + TW'(1);
        end
        if (i_cmd.walk_init) begin
            r_walk_ptr <= (XW'(r_fill) == cap_x) ? r_next : '0;
            r_walk_cnt <= '0;
        end else if (i_cmd.walk_step) begin
            r_walk_ptr <= walk_inc;
            r_walk_cnt <= r_walk_cnt + CW'(1);
        end
        if (i_cmd.mark) begin
            r_mark <= r_walk_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ACTIVE; i++) begin
                r_slot_vld[i] <= 1'b0;
            end
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                r_cnt_vld[i] <= 1'b0;
            end
            r_next <= '0;
            r_fill <= '0;
            r_cand <= '0;
        end else begin
            if (ram_we) begin
                r_cnt_vld[r_rd_addr] <= 1'b1;
            end
            if (i_cmd.load) begin
                // pointers left over from a larger configuration
                if (XW'(r_next) >= cap_x) begin
                    r_next <= '0;
                end
                if (XW'(r_fill) > cap_x) begin
                    r_fill <= CW'(cap_x);
                end
                if (XW'(r_cand) >= total_x) begin
                    r_cand <= '0;
                end
            end
            if (i_cmd.cand_step) begin
                r_cand <= cand_inc;
            end
            if (i_cmd.claim) begin
                r_slot_vld[r_next] <= 1'b1;
                r_cand <= cand_inc;
                r_next <= next_inc;
                if (XW'(r_fill) < cap_x) begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (i_cmd.reuse) begin
                r_next <= next_inc;
            end
        end
    end

    assign blk_out_x = (i_cmd.code == rfpr_pkg::ST_STORED) ? XW'(r_res_blk) :
                       (i_cmd.code == rfpr_pkg::ST_SNAP_ENTRY) ? XW'(slot_rd_blk) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.code;
            r_out_blk    <= blk_out_x[4:0];
            r_out_fill   <= 5'(XW'(r_fill));
            if (i_cmd.code == rfpr_pkg::ST_SNAP_ENTRY) begin
                r_out_chron <= 4'(XW'(r_walk_cnt));
                r_out_last  <= (r_walk_cnt + CW'(1) == r_fill);
            end else begin
                r_out_chron <= '0;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_blk    = r_out_blk;
    assign o_out_chron  = r_out_chron;
    assign o_out_last   = r_out_last;
    assign o_out_fill   = r_out_fill;

    always_comb begin
        o_sts.req          = r_req;
        o_sts.complete     = r_complete;
        o_sts.too_large    = r_len > r_cfg_max;
        o_sts.tgt_out      = XW'(r_tgt) >= total_x;
        o_sts.fill_zero    = r_fill == '0;
        o_sts.cnt_zero     = cnt_q == '0;
        o_sts.cnt_one      = cnt_q == REF_WIDTH'(1);
        o_sts.cnt_max      = cnt_q == '1;
        o_sts.scan_last    = XW'(r_scan_cnt) + XW'(1) == total_x;
        o_sts.slot_valid   = slot_rd_vld;
        o_sts.walk_valid   = slot_rd_vld && (XW'(slot_rd_blk) < total_x);
        o_sts.walk_last    = r_walk_cnt + CW'(1) == r_fill;
        o_sts.walk_at_mark = r_walk_cnt == r_mark;
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

endmodule

[rtl/rfpr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfpr_ctrl
// Request sequencer: steps the datapath through scans, pins and results.
// ----------------------------------------------------------------------------
module rfpr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rfpr_pkg::t_sts i_sts,
    output rfpr_pkg::t_cmd o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_DISPATCH  = 15'b000000000000010,
        S_SCAN_RD   = 15'b000000000000100,
        S_SCAN_CK   = 15'b000000000001000,
        S_OLD_RD    = 15'b000000000010000,
        S_OLD_WR    = 15'b000000000100000,
        S_REUSE_CK  = 15'b000000001000000,
        S_PIN_RD    = 15'b000000010000000,
        S_PIN_CK    = 15'b000000100000000,
        S_UNDO_CHK  = 15'b000001000000000,
        S_UNDO_WR   = 15'b000010000000000,
        S_OUT_ENTRY = 15'b000100000000000,
        S_EMIT      = 15'b001000000000000,
        S_ADD_CK    = 15'b010000000000000,
        S_REL_CK    = 15'b100000000000000
    } t_state;

    t_state            r_state, n_state;
    rfpr_pkg::t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= rfpr_pkg::ST_STORED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.rd_sel  = rfpr_pkg::RS_CAND;
        o_cmd.wr_kind = rfpr_pkg::WK_NONE;
        o_cmd.code    = r_code;
        o_cmd.slot_walk = (r_state == S_PIN_RD) || (r_state == S_PIN_CK) ||
                          (r_state == S_UNDO_CHK) || (r_state == S_UNDO_WR) ||
                          (r_state == S_OUT_ENTRY);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.req)
                    rfpr_pkg::REQ_PUSH: begin
                        if (!i_sts.complete) begin
                            n_code  = rfpr_pkg::ST_INCOMPLETE;
                            n_state = S_EMIT;
                        end else if (i_sts.too_large) begin
                            n_code  = rfpr_pkg::ST_TOO_LARGE;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.rd       = 1'b1;
                            o_cmd.rd_sel   = rfpr_pkg::RS_CAND;
                            o_cmd.scan_clr = 1'b1;
                            n_state = S_SCAN_CK;
                        end
                    end
                    rfpr_pkg::REQ_FREEZE: begin
                        if (i_sts.fill_zero) begin
                            n_code  = rfpr_pkg::ST_SNAP_EMPTY;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state = S_PIN_RD;
                        end
                    end
                    rfpr_pkg::REQ_ADD: begin
                        if (i_sts.tgt_out) begin
                            n_code  = rfpr_pkg::ST_REF_REFUSE;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = rfpr_pkg::RS_TGT;
                            n_state = S_ADD_CK;
                        end
                    end
                    default: begin
                        if (i_sts.tgt_out) begin
                            n_code  = rfpr_pkg::ST_REL_ERROR;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = rfpr_pkg::RS_TGT;
                            n_state = S_REL_CK;
                        end
                    end
                endcase
            end
            S_SCAN_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = rfpr_pkg::RS_CAND;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.wr_kind = rfpr_pkg::WK_SET1;
                    o_cmd.claim   = 1'b1;
                    n_code = rfpr_pkg::ST_STORED;
                    // the displaced block loses the ring's reference
                    n_state = i_sts.slot_valid ? S_OLD_RD : S_EMIT;
                end else if (i_sts.scan_last) begin
                    // one more step brings the candidate back to the scan start
                    o_cmd.cand_step = 1'b1;
                    if (!i_sts.slot_valid) begin
                        n_code  = rfpr_pkg::ST_EXHAUSTED;
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.rd     = 1'b1;
                        o_cmd.rd_sel = rfpr_pkg::RS_SLOT;
                        n_state = S_REUSE_CK;
                    end
                end else begin
                    o_cmd.cand_step = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_OLD_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = rfpr_pkg::RS_OLD;
                n_state = S_OLD_WR;
            end
            S_OLD_WR: begin
                o_cmd.wr_kind = rfpr_pkg::WK_DEC;
                n_state = S_EMIT;
            end
            S_REUSE_CK: begin
                if (i_sts.cnt_one) begin
                    o_cmd.reuse = 1'b1;
                    n_code = rfpr_pkg::ST_STORED;
                end else begin
                    n_code = rfpr_pkg::ST_EXHAUSTED;
                end
                n_state = S_EMIT;
            end
            S_PIN_RD: begin
                if (!i_sts.walk_valid) begin
                    o_cmd.mark      = 1'b1;
                    o_cmd.walk_init = 1'b1;
                    n_state = S_UNDO_CHK;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = rfpr_pkg::RS_SLOT;
                    n_state = S_PIN_CK;
                end
            end
            S_PIN_CK: begin
                if (i_sts.cnt_zero || i_sts.cnt_max) begin
                    o_cmd.mark      = 1'b1;
                    o_cmd.walk_init = 1'b1;
                    n_state = S_UNDO_CHK;
                end else begin
                    o_cmd.wr_kind = rfpr_pkg::WK_INC;
                    if (i_sts.walk_last) begin
                        o_cmd.walk_init = 1'b1;
                        n_state = S_OUT_ENTRY;
                    end else begin
                        o_cmd.walk_step = 1'b1;
                        n_state = S_PIN_RD;
                    end
                end
            end
            S_UNDO_CHK: begin
                if (i_sts.walk_at_mark) begin
                    n_code  = rfpr_pkg::ST_SNAP_EMPTY;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = rfpr_pkg::RS_SLOT;
                    n_state = S_UNDO_WR;
                end
            end
            S_UNDO_WR: begin
                o_cmd.wr_kind   = rfpr_pkg::WK_DEC;
                o_cmd.walk_step = 1'b1;
                n_state = S_UNDO_CHK;
            end
            S_OUT_ENTRY: begin
                o_cmd.code = rfpr_pkg::ST_SNAP_ENTRY;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.walk_step = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ADD_CK: begin
                if (i_sts.cnt_zero || i_sts.cnt_max) begin
                    n_code = rfpr_pkg::ST_REF_REFUSE;
                end else begin
                    o_cmd.wr_kind = rfpr_pkg::WK_INC;
                    n_code = rfpr_pkg::ST_REF_ADDED;
                end
                n_state = S_EMIT;
            end
            S_REL_CK: begin
                if (i_sts.cnt_zero) begin
                    n_code  = rfpr_pkg::ST_REL_ERROR;
                    n_state = S_EMIT;
                end else begin
                    // a good release gives no result
                    o_cmd.wr_kind = rfpr_pkg::WK_DEC;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push, freeze, add and release requests into the frame pool ring
// under random idling and back pressure, predicts every result from a local
// model of the counts and slots, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NACT = 16;
    localparam int NBLK = 32;
    localparam int CNT_MAX = 255;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        rfpr_pkg::t_req req;
        logic           complete;
        logic [23:0]    length;
        logic [4:0]     tgt;
    } t_request;

    typedef struct packed {
        rfpr_pkg::t_status status;
        logic [4:0]        blk;
        logic [3:0]        chron;
        logic              last;
        logic [4:0]        fill;
    } t_result;

    // directed row: request plus optional typed-in last result
    typedef struct {
        t_request          rq;
        bit                known;
        rfpr_pkg::t_status st;
        logic [4:0]        fill;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic [3:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [rfpr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rfpr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    refcounted_frame_pool_ring dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int unsigned pool_cnt[NBLK];
    int unsigned slot_blk[NACT];
    bit          slot_used[NACT];
    int unsigned ring_head, fill_cnt, cand_ptr;
    int unsigned capacity_reg, reserve_reg, payload_reg;

    t_result pending_results[$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    bit      sink_hold = 1'b0;
    bit      no_idle = 1'b0;

    function automatic int unsigned ring_cap();
        int unsigned c;
        c = capacity_reg;
        if (c == 0) c = 1;
        if (c > NACT) c = NACT;
        return c;
    endfunction

    function automatic int unsigned pool_size();
        int unsigned t;
        t = ring_cap() + reserve_reg;
        if (t > NBLK) t = NBLK;
        return t;
    endfunction

    function automatic bit pin_block(int unsigned b, int unsigned total);
        if (b >= total || pool_cnt[b] == 0 || pool_cnt[b] >= CNT_MAX) return 1'b0;
        pool_cnt[b]++;
        return 1'b1;
    endfunction

    function automatic void push_result(rfpr_pkg::t_status st, int unsigned b,
                                        int unsigned ch, bit lst, int unsigned f);
        t_result r;
        r.status = st;
        r.blk = b[4:0];
        r.chron = ch[3:0];
        r.last = lst;
        r.fill = f[4:0];
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void predict_pool(t_request rq);
        int unsigned cap, total, slot, fill, c, b, oldest, n, i;
        bit found, ok;
        cap = ring_cap();
        total = pool_size();
        if (ring_head >= cap) ring_head = 0;
        if (fill_cnt > cap) fill_cnt = cap;
        if (cand_ptr >= total) cand_ptr = 0;
        fill = fill_cnt;
        slot = ring_head;
        case (rq.req)
            rfpr_pkg::REQ_PUSH: begin
                if (!rq.complete) begin
                    push_result(rfpr_pkg::ST_INCOMPLETE, 0, 0, 1, fill);
                    return;
                end
                if (rq.length > payload_reg) begin
                    push_result(rfpr_pkg::ST_TOO_LARGE, 0, 0, 1, fill);
                    return;
                end
                c = cand_ptr;
                found = 0;
                for (i = 0; i < total; i++) begin
                    if (pool_cnt[c] == 0) begin
                        found = 1;
                        break;
                    end
                    c = (c + 1 == total) ? 0 : c + 1;
                end
                if (found) begin
                    ok = slot_used[slot];
                    b = slot_blk[slot];
                    pool_cnt[c] = 1;
                    cand_ptr = (c + 1 == total) ? 0 : c + 1;
                    slot_blk[slot] = c;
                    slot_used[slot] = 1;
                    ring_head = (slot + 1 == cap) ? 0 : slot + 1;
                    if (fill < cap) fill_cnt = fill + 1;
                    if (ok && pool_cnt[b] != 0) pool_cnt[b]--;
                    push_result(rfpr_pkg::ST_STORED, c, 0, 1, fill_cnt);
                    return;
                end
                b = slot_blk[slot];
                if (!slot_used[slot] || pool_cnt[b] != 1) begin
                    push_result(rfpr_pkg::ST_EXHAUSTED, 0, 0, 1, fill);
                    return;
                end
                ring_head = (slot + 1 == cap) ? 0 : slot + 1;
                push_result(rfpr_pkg::ST_STORED, b, 0, 1, fill);
            end
            rfpr_pkg::REQ_FREEZE: begin
                oldest = (fill == cap) ? slot : 0;
                if (fill == 0) begin
                    push_result(rfpr_pkg::ST_SNAP_EMPTY, 0, 0, 1, fill);
                    return;
                end
                ok = 1;
                for (n = 0; n < fill; n++) begin
                    c = (oldest + n) % cap;
                    if (!slot_used[c] || !pin_block(slot_blk[c], total)) begin
                        ok = 0;
                        break;
                    end
                end
                if (!ok) begin
                    for (i = 0; i < n; i++) begin
                        b = slot_blk[(oldest + i) % cap];
                        if (pool_cnt[b] != 0) pool_cnt[b]--;
                    end
                    push_result(rfpr_pkg::ST_SNAP_EMPTY, 0, 0, 1, fill);
                    return;
                end
                for (i = 0; i < fill; i++)
                    push_result(rfpr_pkg::ST_SNAP_ENTRY, slot_blk[(oldest + i) % cap], i,
                                i + 1 == fill, fill);
            end
            rfpr_pkg::REQ_ADD: begin
                if (pin_block(rq.tgt, total))
                    push_result(rfpr_pkg::ST_REF_ADDED, 0, 0, 1, fill);
                else
                    push_result(rfpr_pkg::ST_REF_REFUSE, 0, 0, 1, fill);
            end
            default: begin
                if (rq.tgt >= total || pool_cnt[rq.tgt] == 0)
                    push_result(rfpr_pkg::ST_REL_ERROR, 0, 0, 1, fill);
                else
                    pool_cnt[rq.tgt]--;
            end
        endcase
    endfunction

    // watchdog on cycles without any accepted transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result sink with random stalls
    always @(posedge i_clk) begin
        t_result exp_r;
        if (o_m_tvalid && i_m_tready && i_rst_n) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result status=%0d", o_m_tuser);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_tuser !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_m_tuser);
                    fail_count++;
                end
                if (o_m_tdata[4:0] !== exp_r.blk) begin
                    $error("result_block exp %0d got %0d", exp_r.blk, o_m_tdata[4:0]);
                    fail_count++;
                end
                if (o_m_tdata[8:5] !== exp_r.chron) begin
                    $error("chron_index exp %0d got %0d", exp_r.chron, o_m_tdata[8:5]);
                    fail_count++;
                end
                if (o_m_tlast !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, o_m_tlast);
                    fail_count++;
                end
                if (o_m_tdata[13:9] !== exp_r.fill) begin
                    $error("ring_fill exp %0d got %0d", exp_r.fill, o_m_tdata[13:9]);
                    fail_count++;
                end
            end
        end
        i_m_tready <= !sink_hold && (no_idle || $urandom_range(99) >= 29);
    end

    task automatic write_reg(logic [rfpr_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[23:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            rfpr_pkg::CFG_ACTIVE_CAPACITY: capacity_reg = val & 5'h1f;
            rfpr_pkg::CFG_RESERVE_BLOCKS:  reserve_reg = val & 5'h1f;
            rfpr_pkg::CFG_MAX_PAYLOAD:     payload_reg = val & 24'hffffff;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        // a release can be in flight with no result
        repeat (12) @(posedge i_clk);
    endtask

    // sends one request and updates the predictor once it is accepted
    task automatic send_request(t_request rq);
        if (!no_idle)
            while ($urandom_range(99) < 29) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= rq.req;
        i_s_tdata <= {2'b0, rq.tgt, rq.length, rq.complete};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_pool(rq);
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
    endtask

    function automatic t_request rand_request(int mode);
        t_request rq;
        int unsigned p;
        int unsigned tmax;
        tmax = (mode == 1 || pool_size() > 31) ? 31 : pool_size();
        rq.tgt = 5'($urandom_range(tmax));
        rq.complete = $urandom_range(19) != 0;
        p = $urandom_range(99);
        rq.length = (p < 5) ? 24'hffffff : (p < 10) ? 24'(payload_reg) : 24'($urandom);
        if ($urandom_range(1)) rq.length = 24'(32'(rq.length) % (payload_reg + 1));
        p = $urandom_range(99);
        rq.req = (p < 45) ? rfpr_pkg::REQ_PUSH : (p < 60) ? rfpr_pkg::REQ_FREEZE :
                 (p < 78) ? rfpr_pkg::REQ_ADD : rfpr_pkg::REQ_RELEASE;
        return rq;
    endfunction

    t_row directed_rows[$];

    function automatic void add_row(rfpr_pkg::t_req q, bit cpl, int unsigned len,
                                    int unsigned tgt, bit known,
                                    rfpr_pkg::t_status st, int unsigned fill);
        t_row r;
        r.rq.req = q;
        r.rq.complete = cpl;
        r.rq.length = 24'(len);
        r.rq.tgt = 5'(tgt);
        r.known = known;
        r.st = st;
        r.fill = 5'(fill);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    initial begin
        t_request rq;
        t_result chk;
        capacity_reg = rfpr_pkg::RST_ACTIVE_CAPACITY;
        reserve_reg = rfpr_pkg::RST_RESERVE_BLOCKS;
        payload_reg = rfpr_pkg::RST_MAX_PAYLOAD;
        foreach (pool_cnt[k]) pool_cnt[k] = 0;
        foreach (slot_used[k]) begin
            slot_used[k] = 0;
            slot_blk[k] = 0;
        end
        ring_head = 0;
        fill_cnt = 0;
        cand_ptr = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, after reset state
        add_row(rfpr_pkg::REQ_FREEZE, 0, 0, 0, 1, rfpr_pkg::ST_SNAP_EMPTY, 0);
        add_row(rfpr_pkg::REQ_RELEASE, 0, 0, 0, 1, rfpr_pkg::ST_REL_ERROR, 0);
        add_row(rfpr_pkg::REQ_ADD, 0, 0, 31, 1, rfpr_pkg::ST_REF_REFUSE, 0);
        add_row(rfpr_pkg::REQ_ADD, 0, 0, 3, 1, rfpr_pkg::ST_REF_REFUSE, 0);
        add_row(rfpr_pkg::REQ_PUSH, 0, 0, 0, 1, rfpr_pkg::ST_INCOMPLETE, 0);
        add_row(rfpr_pkg::REQ_PUSH, 1, 24'hffffff, 0, 1, rfpr_pkg::ST_TOO_LARGE, 0);
        add_row(rfpr_pkg::REQ_PUSH, 1, rfpr_pkg::RST_MAX_PAYLOAD, 31, 1,
                rfpr_pkg::ST_STORED, 1);
        add_row(rfpr_pkg::REQ_PUSH, 1, 0, 0, 1, rfpr_pkg::ST_STORED, 2);
        add_row(rfpr_pkg::REQ_ADD, 0, 0, 0, 1, rfpr_pkg::ST_REF_ADDED, 2);
        add_row(rfpr_pkg::REQ_RELEASE, 0, 0, 0, 0, rfpr_pkg::ST_STORED, 0);
        add_row(rfpr_pkg::REQ_RELEASE, 0, 0, 31, 1, rfpr_pkg::ST_REL_ERROR, 2);
        add_row(rfpr_pkg::REQ_FREEZE, 0, 0, 0, 0, rfpr_pkg::ST_STORED, 0);
        add_row(rfpr_pkg::REQ_RELEASE, 0, 0, 1, 0, rfpr_pkg::ST_STORED, 0);
        add_row(rfpr_pkg::REQ_RELEASE, 0, 0, 1, 0, rfpr_pkg::ST_STORED, 0);
        add_row(rfpr_pkg::REQ_FREEZE, 0, 0, 0, 1, rfpr_pkg::ST_SNAP_EMPTY, 2);
        add_row(rfpr_pkg::REQ_PUSH, 1, 5, 21, 0, rfpr_pkg::ST_STORED, 0);
        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].rq);
            if (directed_rows[k].known) begin
                chk = pending_results[pending_results.size() - 1];
                if (chk.status !== directed_rows[k].st) begin
                    $error("status exp %0d got %0d (table)", directed_rows[k].st,
                           chk.status);
                    fail_count++;
                end
                if (chk.fill !== directed_rows[k].fill) begin
                    $error("ring_fill exp %0d got %0d (table)", directed_rows[k].fill,
                           chk.fill);
                    fail_count++;
                end
            end
        end
        stop_sending();
        drain_results();

        // saturate block 0, then over-add
        no_idle = 1'b1;
        for (int k = 0; k < CNT_MAX; k++) begin
            rq = '{rfpr_pkg::REQ_ADD, 1'b0, 24'd0, 5'd0};
            send_request(rq);
        end
        stop_sending();
        drain_results();
        no_idle = 1'b0;

        // random phases over several settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(rfpr_pkg::CFG_ACTIVE_CAPACITY, 1);
                    write_reg(rfpr_pkg::CFG_RESERVE_BLOCKS, 0);
                    write_reg(rfpr_pkg::CFG_MAX_PAYLOAD, 1);
                end
                1: begin
                    write_reg(rfpr_pkg::CFG_ACTIVE_CAPACITY, 4);
                    write_reg(rfpr_pkg::CFG_RESERVE_BLOCKS, 2);
                    write_reg(rfpr_pkg::CFG_MAX_PAYLOAD, 24'hffffff);
                end
                2: begin
                    write_reg(rfpr_pkg::CFG_ACTIVE_CAPACITY, 0);
                    write_reg(rfpr_pkg::CFG_RESERVE_BLOCKS, 1);
                end
                3: begin
                    write_reg(rfpr_pkg::CFG_ACTIVE_CAPACITY, 31);
                    write_reg(rfpr_pkg::CFG_RESERVE_BLOCKS, 31);
                    write_reg(rfpr_pkg::CFG_MAX_PAYLOAD, $urandom_range(1, 24'hffffff));
                end
                4: begin
                    write_reg(rfpr_pkg::CFG_ACTIVE_CAPACITY, 3);
                    write_reg(rfpr_pkg::CFG_RESERVE_BLOCKS, 0);
                end
                default: begin
                    write_reg(rfpr_pkg::CFG_ACTIVE_CAPACITY, 16);
                    write_reg(rfpr_pkg::CFG_RESERVE_BLOCKS, 16);
                    write_reg(rfpr_pkg::CFG_MAX_PAYLOAD, 1000);
                end
            endcase
            no_idle = (ph == 2);
            if (ph == 3) begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        sink_hold = 1'b1;
                        repeat (600) @(posedge i_clk);
                        sink_hold = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 17; k++) begin
                send_request(rand_request(k % 7 == 0));
                if (k == 8) begin
                    // sender pause until all results are in
                    stop_sending();
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            end
            stop_sending();
            drain_results();
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
